[hdl/sst_pkg.sv]
// shared types and constants for the sorted set table
// no dependencies; imported by every module of the block

package sst_pkg;

   // fixed port widths
   localparam int CNT_W  = 9;
   localparam int POS_W  = 8;
   localparam int OP_W   = 2;
   localparam int ITEM_W = 32;

   // parameter defaults and reset values
   localparam int CAPACITY_DEF    = 256;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam logic [CNT_W-1:0] MAX_ITEMS_RST = 9'd150;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_ERASE    = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_GET      = 2'd3
   } op_type;

   // result of the shared compare unit, stored word against key
   typedef struct packed {
      logic eq;   // stored word equals key
      logic lt;   // stored word below key
   } cmp_res_type;

endpackage

[hdl/sorted_set_table.sv]
// sorted_set_table: descending sorted set of unique values in one memory.
// an insert into a full set skips the search and fails.
// throughput: one request at a time; the linear search and shift, one store word
// per cycle, set the rate.
// reset: synchronous, clears the count and restores max_items to 150; the
// value store is not cleared, only entries below the count are ever read.
// depends on sst_pkg, sst_mem and sst_cmp

module sorted_set_table #(
   parameter int CAPACITY    = sst_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = sst_pkg::VALUE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sst_pkg::CNT_W-1:0]   csr_max_items,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sst_pkg::OP_W-1:0]    req_operation,
   input  logic [sst_pkg::ITEM_W-1:0]  req_item_value,
   input  logic [sst_pkg::POS_W-1:0]   req_position,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_success,
   output logic [sst_pkg::ITEM_W-1:0]  rsp_result_value,
   output logic [sst_pkg::CNT_W-1:0]   rsp_item_count,
   output logic                        rsp_is_empty
);
   import sst_pkg::*;

   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam logic [CNT_W-1:0] CAP_CLIP =
      CNT_W'((CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_SHUP = 6'b000100,
      ST_SHDN = 6'b001000,
      ST_GETW = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   ok_ff, ok_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       max_items_ff, max_items_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_success_ff, rsp_success_in;
   logic [ITEM_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   mem_rd_en;
   logic [CNT_W-1:0]       mem_rd_idx;
   logic                   mem_wr_en;
   logic [CNT_W-1:0]       mem_wr_idx;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic [VALUE_WIDTH-1:0] mem_rd_data;
   cmp_res_type            cmp_res;

   logic                   req_accept;
   logic [CNT_W-1:0]       limit;
   logic                   scan_hit;
   logic                   scan_end;
   logic                   found;
   logic [CNT_W-1:0]       hit_pos;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // limit in force, clipped to the store
   assign limit = (max_items_ff > CAP_CLIP) ? CAP_CLIP : max_items_ff;

   // value store
   sst_mem #(
      .DEPTH  (CAPACITY),
      .WIDTH  (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ADDR_W'(mem_wr_idx)),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ADDR_W'(mem_rd_idx)),
      .rd_data (mem_rd_data)
   );

   // shared compare of the word just read against the key
   sst_cmp #(
      .WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .stored (mem_rd_data),
      .key    (key_ff),
      .res    (cmp_res)
   );

   // search outcome: stop at a match or at the first smaller word
   assign scan_hit = pend_vld_ff && (cmp_res.eq || cmp_res.lt);
   assign scan_end = !pend_vld_ff && (rem_ff == '0);
   assign found    = pend_vld_ff && cmp_res.eq;
   assign hit_pos  = scan_hit ? pend_idx_ff : count_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rd_idx_in    = rd_idx_ff;
      rem_in       = rem_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      hit_idx_in   = hit_idx_ff;
      ok_in        = ok_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      mem_rd_en    = 1'b0;
      mem_rd_idx   = rd_idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_idx   = pend_idx_ff;
      mem_wr_data  = mem_rd_data;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_success_in = rsp_success_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = op_type'(req_operation);
               key_in      = VALUE_WIDTH'(req_item_value);
               ok_in       = 1'b0;
               val_in      = '0;
               pend_vld_in = 1'b0;
               rd_idx_in   = '0;
               rem_in      = count_ff;
               case (op_type'(req_operation))
                  OP_INSERT: begin
                     state_in = (count_ff >= limit) ? ST_FIN : ST_SCAN;
                  end
                  OP_GET: begin
                     if (CNT_W'(req_position) < count_ff) begin
                        mem_rd_en  = 1'b1;
                        mem_rd_idx = CNT_W'(req_position);
                        state_in   = ST_GETW;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end

         ST_GETW: begin
            ok_in    = 1'b1;
            val_in   = mem_rd_data;
            state_in = ST_FIN;
         end

         ST_SCAN: begin
            // read ahead one word per cycle
            pend_vld_in = (rem_ff != '0);
            pend_idx_in = rd_idx_ff;
            if (rem_ff != '0) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + ONE;
               rem_in    = rem_ff - ONE;
            end
            if (scan_hit || scan_end) begin
               pend_vld_in = 1'b0;
               hit_idx_in  = hit_pos;
               case (op_ff)
                  OP_ERASE: begin
                     if (found) begin
                        ok_in     = 1'b1;
                        rd_idx_in = hit_pos + ONE;
                        rem_in    = count_ff - hit_pos - ONE;
                        state_in  = ST_SHDN;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  OP_INSERT: begin
                     if (found) begin
                        state_in = ST_FIN;
                     end else begin
                        ok_in     = 1'b1;
                        rd_idx_in = count_ff - ONE;
                        rem_in    = count_ff - hit_pos;
                        state_in  = ST_SHUP;
                     end
                  end
                  default: begin
                     ok_in    = found;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_SHUP: begin
            // move words one place toward the tail, last word first
            pend_vld_in = (rem_ff != '0);
            pend_idx_in = rd_idx_ff;
            if (rem_ff != '0) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff - ONE;
               rem_in    = rem_ff - ONE;
            end
            if (pend_vld_ff) begin
               mem_wr_en  = 1'b1;
               mem_wr_idx = pend_idx_ff + ONE;
            end else if (rem_ff == '0) begin
               // gap is open, drop the new value in
               mem_wr_en   = 1'b1;
               mem_wr_idx  = hit_idx_ff;
               mem_wr_data = key_ff;
               count_in    = count_ff + ONE;
               state_in    = ST_FIN;
            end
         end

         ST_SHDN: begin
            // close the gap, words move one place toward the head
            pend_vld_in = (rem_ff != '0);
            pend_idx_in = rd_idx_ff;
            if (rem_ff != '0) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + ONE;
               rem_in    = rem_ff - ONE;
            end
            if (pend_vld_ff) begin
               mem_wr_en  = 1'b1;
               mem_wr_idx = pend_idx_ff - ONE;
            end else if (rem_ff == '0) begin
               count_in = count_ff - ONE;
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            // hand the result beat to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = ok_ff;
               rsp_value_in   = ITEM_W'(val_ff);
               rsp_count_in   = count_ff;
               rsp_empty_in   = (count_ff == '0);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration register
   assign max_items_in = csr_valid ? csr_max_items : max_items_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_vld_ff  <= 1'b0;
         count_ff     <= '0;
         max_items_ff <= MAX_ITEMS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_vld_ff  <= pend_vld_in;
         count_ff     <= count_in;
         max_items_ff <= max_items_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      rem_ff         <= rem_in;
      pend_idx_ff    <= pend_idx_in;
      hit_idx_ff     <= hit_idx_in;
      ok_ff          <= ok_in;
      val_ff         <= val_in;
      rsp_success_ff <= rsp_success_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_item_count   = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;

   // count never passes the store size
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CLIP)
      else $error("item count beyond store size");

   // shifts and placement stay inside the held range plus the new slot
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (mem_wr_idx <= count_ff))
      else $error("store write outside held range");

   // no read is still in flight when the result is handed over
   a_fin_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> !pend_vld_ff)
      else $error("result with pending store read");

   // empty flag agrees with the reported count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == '0)))
      else $error("empty flag disagrees with count");

   // a failed beat never carries a value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_success_ff) |-> (rsp_value_ff == '0))
      else $error("failed result carries a value");

endmodule

[hdl/sst_mem.sv]
// value store: one write port, one registered read port
// depends on sst_pkg (imported for house consistency, no types used at ports)

module sst_mem #(
   parameter int DEPTH  = sst_pkg::CAPACITY_DEF,
   parameter int WIDTH  = sst_pkg::VALUE_WIDTH_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   import sst_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sst_cmp.sv]
// shared magnitude compare unit used by every search step
// depends on sst_pkg for the compare result struct

module sst_cmp #(
   parameter int WIDTH = sst_pkg::VALUE_WIDTH_DEF
) (
   input  logic [WIDTH-1:0]   stored,
   input  logic [WIDTH-1:0]   key,
   output sst_pkg::cmp_res_type res
);
   import sst_pkg::*;

   // equality and unsigned less-than of the stored word
   always_comb begin
      res.eq = (stored == key);
      res.lt = (stored < key);
   end

endmodule
